// File: rtl/md5md_pkg.sv
`timescale 1ns / 1ps

package md5md_pkg;

    // block geometry
    localparam int MSG_WORDS   = 16;
    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam int WORD_BITS   = 32;
    localparam int LANES       = WORD_BITS / 8;
    localparam int ADDR_BITS   = $clog2(MSG_WORDS);
    localparam int FILL_BITS   = $clog2(BLOCK_BYTES);
    localparam int RND_BITS    = $clog2(ROUNDS);

    // padding layout
    localparam logic [7:0]           PAD_BYTE    = 8'h80;
    localparam logic [FILL_BITS-1:0] LEN_POS     = FILL_BITS'(56);
    localparam logic [FILL_BITS-1:0] FILL_LAST   = FILL_BITS'(BLOCK_BYTES - 1);
    localparam logic [RND_BITS-1:0]  ROUND_LAST  = RND_BITS'(ROUNDS - 1);
    localparam logic [ADDR_BITS-1:0] LEN_LO_WORD = ADDR_BITS'(14);
    localparam logic [ADDR_BITS-1:0] LEN_HI_WORD = ADDR_BITS'(15);
    // zero fill pointer is one bit wider so it can step past the last word
    localparam logic [ADDR_BITS:0]   ZERO_LAST_ONE = (ADDR_BITS + 1)'(13);
    localparam logic [ADDR_BITS:0]   ZERO_LAST_TWO = (ADDR_BITS + 1)'(MSG_WORDS - 1);

    typedef struct packed {
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] c;
        logic [WORD_BITS-1:0] d;
    } abcd_t;

    localparam abcd_t INIT_CHAIN = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    // write port of the message block memory
    typedef struct packed {
        logic                 we;
        logic [LANES-1:0]     be;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] data;
    } ram_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_START,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        CTX_BLOCK,
        CTX_PAD1,
        CTX_FINAL
    } ctx_t;

    localparam logic [WORD_BITS-1:0] K_TABLE [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by a round
    function automatic logic [ADDR_BITS-1:0] msg_index(input logic [RND_BITS-1:0] rnd);
        logic [ADDR_BITS-1:0] r4;
        logic [ADDR_BITS-1:0] idx;
        r4 = rnd[ADDR_BITS-1:0];
        unique case (rnd[RND_BITS-1:RND_BITS-2])
            2'd0: idx = r4;
            2'd1: idx = ADDR_BITS'(r4 * ADDR_BITS'(5)) + ADDR_BITS'(1);
            2'd2: idx = ADDR_BITS'(r4 * ADDR_BITS'(3)) + ADDR_BITS'(5);
            2'd3: idx = ADDR_BITS'(r4 * ADDR_BITS'(7));
        endcase
        return idx;
    endfunction

endpackage

// File: rtl/md5md_msg_ram.sv
`timescale 1ns / 1ps

module md5md_msg_ram (
    input  logic                                  clk,
    input  md5md_pkg::ram_wr_t                    wr,
    input  logic [md5md_pkg::ADDR_BITS-1:0]       raddr,
    output logic [md5md_pkg::WORD_BITS-1:0]       rdata
);

    logic [md5md_pkg::WORD_BITS-1:0] mem [md5md_pkg::MSG_WORDS];

    // byte-lane write
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            for (int l = 0; l < md5md_pkg::LANES; l++)
            begin
                if (wr.be[l])
                begin
                    mem[wr.addr][8*l +: 8] <= wr.data[8*l +: 8];
                end
            end
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/md5md_round.sv
`timescale 1ns / 1ps

module md5md_round (
    input  logic [md5md_pkg::RND_BITS-1:0]  rnd,
    input  md5md_pkg::abcd_t                cur,
    input  logic [md5md_pkg::WORD_BITS-1:0] m,
    output md5md_pkg::abcd_t                nxt
);

    logic [md5md_pkg::WORD_BITS-1:0]   f;
    logic [md5md_pkg::WORD_BITS-1:0]   sum;
    logic [4:0]                        rot;
    logic [2*md5md_pkg::WORD_BITS-1:0] dbl;
    logic [md5md_pkg::WORD_BITS-1:0]   t;

    // boolean function of the current phase
    always_comb
    begin
        unique case (rnd[md5md_pkg::RND_BITS-1:md5md_pkg::RND_BITS-2])
            2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
            2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
            2'd2: f = cur.b ^ cur.c ^ cur.d;
            2'd3: f = cur.c ^ (cur.b | ~cur.d);
        endcase
    end

    // add, rotate left, add
    assign sum = cur.a + f + m + md5md_pkg::K_TABLE[rnd];
    assign rot = md5md_pkg::ROT_TABLE[{rnd[md5md_pkg::RND_BITS-1:md5md_pkg::RND_BITS-2], rnd[1:0]}];
    assign dbl = {sum, sum} << rot;
    assign t   = dbl[2*md5md_pkg::WORD_BITS-1:md5md_pkg::WORD_BITS] + cur.b;

    // word rotation
    assign nxt = '{a: cur.d, b: t, c: cur.b, d: cur.c};

endmodule

// File: rtl/md5_message_digest_unit.sv
`timescale 1ns / 1ps

// channel | signals                                 | moves
// --------+-----------------------------------------+---------------------------------
// in      | in_valid in_ready msg_byte byte_valid   | one message byte or closing
//         | is_last                                 | request
// out     | out_valid out_ready digest_a..digest_d  | one 128-bit digest per message
//
// the 64th byte of a block is followed by a compression (one read set-up, 64 rounds,
// one chaining add) bound by the single round unit and the one read port of the block
// memory
// a closing request takes a pad write, up to 13 zero-word writes, an exit from the zero
// fill, 2 length writes and one compression, or two compressions when the pad spills
// past byte 55
// reset gives the initial chaining words, an empty block and a zero byte count
// in_ready is low during padding and compression; a waiting digest stalls only the
// end of the next message

module md5_message_digest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        byte_valid,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_a,
    output logic [31:0] digest_b,
    output logic [31:0] digest_c,
    output logic [31:0] digest_d
);

    md5md_pkg::state_t state_reg, state_next;
    md5md_pkg::ctx_t   ctx_reg, ctx_next;
    logic [md5md_pkg::FILL_BITS-1:0] fill_reg, fill_next;
    logic [31:0]                     count_reg, count_next;
    logic                            last_pend_reg, last_pend_next;
    logic                            pad_two_reg, pad_two_next;
    logic [md5md_pkg::ADDR_BITS:0]   wptr_reg, wptr_next;
    logic [md5md_pkg::RND_BITS-1:0]  rnd_reg, rnd_next;
    md5md_pkg::abcd_t                work_reg, work_next;
    md5md_pkg::abcd_t                chain_reg, chain_next;
    md5md_pkg::abcd_t                digest_reg, digest_next;
    logic                            out_valid_reg, out_valid_next;

    md5md_pkg::ram_wr_t              ram_wr;
    logic [md5md_pkg::ADDR_BITS-1:0] ram_raddr;
    logic [md5md_pkg::WORD_BITS-1:0] ram_rdata;
    md5md_pkg::abcd_t                round_out;
    md5md_pkg::abcd_t                chain_sum;
    logic [md5md_pkg::ADDR_BITS:0]   zero_limit;
    logic                            in_acc;

    md5md_msg_ram u_msg_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5md_round u_round (
        .rnd (rnd_reg),
        .cur (work_reg),
        .m   (ram_rdata),
        .nxt (round_out)
    );

    assign in_ready   = (state_reg == md5md_pkg::ST_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign zero_limit = pad_two_reg ? md5md_pkg::ZERO_LAST_TWO : md5md_pkg::ZERO_LAST_ONE;

    // chaining add after the last round
    assign chain_sum = '{
        a: chain_reg.a + work_reg.a,
        b: chain_reg.b + work_reg.b,
        c: chain_reg.c + work_reg.c,
        d: chain_reg.d + work_reg.d
    };

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5md_pkg::ST_IDLE;
            ctx_reg       <= md5md_pkg::CTX_BLOCK;
            fill_reg      <= '0;
            count_reg     <= '0;
            last_pend_reg <= 1'b0;
            pad_two_reg   <= 1'b0;
            wptr_reg      <= '0;
            rnd_reg       <= '0;
            chain_reg     <= md5md_pkg::INIT_CHAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctx_reg       <= ctx_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            last_pend_reg <= last_pend_next;
            pad_two_reg   <= pad_two_next;
            wptr_reg      <= wptr_next;
            rnd_reg       <= rnd_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working words and digest
    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        digest_reg <= digest_next;
    end

    // next state, memory accesses
    always_comb
    begin
        state_next     = state_reg;
        ctx_next       = ctx_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        last_pend_next = last_pend_reg;
        pad_two_next   = pad_two_reg;
        wptr_next      = wptr_reg;
        rnd_next       = rnd_reg;
        work_next      = work_reg;
        chain_next     = chain_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_wr         = '0;
        ram_raddr      = md5md_pkg::msg_index(rnd_reg + md5md_pkg::RND_BITS'(1));

        unique case (state_reg)
            md5md_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    // byte lane write
                    if (byte_valid)
                    begin
                        ram_wr.we   = 1'b1;
                        ram_wr.addr = fill_reg[md5md_pkg::FILL_BITS-1:2];
                        ram_wr.be   = md5md_pkg::LANES'(1) << fill_reg[1:0];
                        ram_wr.data = {md5md_pkg::LANES{msg_byte}};
                        fill_next   = fill_reg + md5md_pkg::FILL_BITS'(1);
                        count_next  = count_reg + 32'd1;
                    end
                    if (byte_valid && fill_reg == md5md_pkg::FILL_LAST)
                    begin
                        state_next     = md5md_pkg::ST_START;
                        ctx_next       = md5md_pkg::CTX_BLOCK;
                        last_pend_next = is_last;
                    end
                    else if (is_last)
                    begin
                        state_next = md5md_pkg::ST_PAD;
                    end
                end
            end

            md5md_pkg::ST_PAD:
            begin
                // pad byte, zero the lanes above it
                ram_wr.we    = 1'b1;
                ram_wr.addr  = fill_reg[md5md_pkg::FILL_BITS-1:2];
                ram_wr.be    = {md5md_pkg::LANES{1'b1}} << fill_reg[1:0];
                ram_wr.data  = md5md_pkg::WORD_BITS'(md5md_pkg::PAD_BYTE) << {fill_reg[1:0], 3'b000};
                wptr_next    = {1'b0, fill_reg[md5md_pkg::FILL_BITS-1:2]}
                             + (md5md_pkg::ADDR_BITS + 1)'(1);
                pad_two_next = (fill_reg >= md5md_pkg::LEN_POS);
                state_next   = md5md_pkg::ST_ZERO;
            end

            md5md_pkg::ST_ZERO:
            begin
                if (wptr_reg <= zero_limit)
                begin
                    ram_wr.we   = 1'b1;
                    ram_wr.addr = wptr_reg[md5md_pkg::ADDR_BITS-1:0];
                    ram_wr.be   = {md5md_pkg::LANES{1'b1}};
                    ram_wr.data = '0;
                    wptr_next   = wptr_reg + (md5md_pkg::ADDR_BITS + 1)'(1);
                end
                else if (pad_two_reg)
                begin
                    state_next = md5md_pkg::ST_START;
                    ctx_next   = md5md_pkg::CTX_PAD1;
                end
                else
                begin
                    state_next = md5md_pkg::ST_LEN_LO;
                end
            end

            md5md_pkg::ST_LEN_LO:
            begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = md5md_pkg::LEN_LO_WORD;
                ram_wr.be   = {md5md_pkg::LANES{1'b1}};
                ram_wr.data = {count_reg[28:0], 3'b000};
                state_next  = md5md_pkg::ST_LEN_HI;
            end

            md5md_pkg::ST_LEN_HI:
            begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = md5md_pkg::LEN_HI_WORD;
                ram_wr.be   = {md5md_pkg::LANES{1'b1}};
                ram_wr.data = {29'd0, count_reg[31:29]};
                state_next  = md5md_pkg::ST_START;
                ctx_next    = md5md_pkg::CTX_FINAL;
            end

            md5md_pkg::ST_START:
            begin
                // fetch the first message word
                ram_raddr  = md5md_pkg::msg_index('0);
                work_next  = chain_reg;
                rnd_next   = '0;
                state_next = md5md_pkg::ST_ROUND;
            end

            md5md_pkg::ST_ROUND:
            begin
                work_next = round_out;
                rnd_next  = rnd_reg + md5md_pkg::RND_BITS'(1);
                if (rnd_reg == md5md_pkg::ROUND_LAST)
                begin
                    state_next = md5md_pkg::ST_FINISH;
                end
            end

            md5md_pkg::ST_FINISH:
            begin
                unique case (ctx_reg)
                    md5md_pkg::CTX_BLOCK:
                    begin
                        chain_next     = chain_sum;
                        last_pend_next = 1'b0;
                        state_next     = last_pend_reg ? md5md_pkg::ST_PAD : md5md_pkg::ST_IDLE;
                    end
                    md5md_pkg::CTX_PAD1:
                    begin
                        chain_next   = chain_sum;
                        pad_two_next = 1'b0;
                        wptr_next    = '0;
                        state_next   = md5md_pkg::ST_ZERO;
                    end
                    md5md_pkg::CTX_FINAL:
                    begin
                        // hand over the digest once the output register is free
                        if (!out_valid_reg || out_ready)
                        begin
                            digest_next    = chain_sum;
                            out_valid_next = 1'b1;
                            chain_next     = md5md_pkg::INIT_CHAIN;
                            fill_next      = '0;
                            count_next     = '0;
                            state_next     = md5md_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = md5md_pkg::ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = md5md_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign digest_a  = digest_reg.a;
    assign digest_b  = digest_reg.b;
    assign digest_c  = digest_reg.c;
    assign digest_d  = digest_reg.d;

    // no block write while the rounds read the memory
    a_no_write_in_rounds : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == md5md_pkg::ST_ROUND |-> !ram_wr.we)
        else $error("block memory written during compression");

    // a full block starts compression
    a_full_block_compresses : assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && byte_valid && fill_reg == md5md_pkg::FILL_LAST
        |=> state_reg == md5md_pkg::ST_START)
        else $error("full block did not start compression");

    // round 63 ends the compression
    a_rounds_end : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == md5md_pkg::ST_ROUND && rnd_reg == md5md_pkg::ROUND_LAST
        |=> state_reg == md5md_pkg::ST_FINISH)
        else $error("compression did not finish after the last round");

    // a digest appears only from the final compression
    a_digest_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg)
        |-> $past(state_reg == md5md_pkg::ST_FINISH && ctx_reg == md5md_pkg::CTX_FINAL))
        else $error("digest raised outside the final compression");

endmodule
